// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/mrs_pkg.sv =====
// Types and constants shared by the monotonic run segmenter modules.
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  localparam logic KIND_RUN      = 1'b0;
  localparam logic KIND_ENDPOINT = 1'b1;

  // One queue entry: every record caused by one input sample.
  typedef struct packed {
    logic                block_last;
    logic                has_turn;
    logic [LEN_W-1:0]    turn_len;
    logic [SAMPLE_W-1:0] turn_val;
    logic                has_close;
    logic [LEN_W-1:0]    close_len;
    logic [SAMPLE_W-1:0] close_val;
    logic                has_end;
    logic [SAMPLE_W-1:0] end_val;
  } mrs_entry_t;

endpackage

// ===== hw/rtl/monotonic_run_segmenter.sv =====
// A sample's first record passes through the queue and then the output register.
// One sample per cycle while the queue has room; a sample yields zero to three records.
// One record leaves per cycle unless out_tready stalls; a four-entry queue absorbs bursts.
// Synchronous reset (rst_n low) clears run state, queue pointers and output valid.
`timescale 1ns / 1ps
module monotonic_run_segmenter #(
  parameter int MAX_LEN = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mrs_pkg::IN_TDATA_W-1:0]  in_tdata,  // [15:0] sample
  input  logic                            in_tlast,  // block_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mrs_pkg::OUT_TDATA_W-1:0] out_tdata, // [9:0] run_length, [25:10] value
  output logic                            out_tuser, // [0] kind
  output logic                            out_tlast  // last_of_block
);
  import mrs_pkg::*;

  logic       q_full;
  logic       accept;
  logic       push;
  mrs_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  mrs_entry_t head_entry;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  mrs_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_tdata[SAMPLE_W-1:0]),
    .block_end  (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  mrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/mrs_front.sv =====
// Front end: tracks run state per sample and builds one record bundle.
`timescale 1ns / 1ps
module mrs_front #(
  parameter int MAX_LEN = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [mrs_pkg::SAMPLE_W-1:0] sample,
  input  logic                        block_end,
  output logic                        push,
  output mrs_pkg::mrs_entry_t         push_entry
);
  import mrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                have_prev_r, have_prev_nxt;
  dir_t                dir_r, dir_nxt;
  logic [SAMPLE_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] last_start_r, last_start_nxt;
  logic                any_run_r, any_run_nxt;

  dir_t                step_dir;
  dir_t                dir_upd;
  logic [SAMPLE_W-1:0] start_upd;
  logic [CNT_W-1:0]    cnt_upd;
  logic                turn;
  logic                close;
  logic                endpoint;
  logic [SAMPLE_W-1:0] last_start_eff;
  logic                any_eff;
  logic [CNT_W+LEN_W-1:0] old_ext, upd_ext;
  logic [LEN_W-1:0]    old_len, upd_len;

  always_comb begin
    if ($signed(sample) > $signed(prev_r)) begin
      step_dir = DIR_UP;
    end else if ($signed(sample) < $signed(prev_r)) begin
      step_dir = DIR_DOWN;
    end else begin
      step_dir = DIR_NONE;
    end
  end

  // Run update for this sample, before block-end handling.
  always_comb begin
    dir_upd   = dir_r;
    start_upd = start_r;
    cnt_upd   = cnt_r;
    turn      = 1'b0;
    if (have_prev_r) begin
      if (dir_r == DIR_NONE) begin
        if (step_dir != DIR_NONE) begin
          dir_upd   = step_dir;
          start_upd = prev_r;
          cnt_upd   = CNT_TWO;
        end
      end else if (step_dir == DIR_NONE || step_dir == dir_r) begin
        if (cnt_r < MAX_CNT) begin
          cnt_upd = cnt_r + 1'b1;
        end
      end else begin
        turn      = 1'b1;
        dir_upd   = step_dir;
        start_upd = prev_r;
        cnt_upd   = CNT_TWO;
      end
    end
  end

  // Signed lengths, wrapped to the output field width.
  always_comb begin
    old_ext = {{LEN_W{1'b0}}, cnt_r};
    upd_ext = {{LEN_W{1'b0}}, cnt_upd};
    old_len = (dir_r == DIR_DOWN) ? -old_ext[LEN_W-1:0] : old_ext[LEN_W-1:0];
    upd_len = (dir_upd == DIR_DOWN) ? -upd_ext[LEN_W-1:0] : upd_ext[LEN_W-1:0];
  end

  always_comb begin
    close = block_end && (dir_upd != DIR_NONE);
    if (close) begin
      last_start_eff = start_upd;
    end else if (turn) begin
      last_start_eff = start_r;
    end else begin
      last_start_eff = last_start_r;
    end
    any_eff  = any_run_r | turn | close;
    endpoint = block_end && (!any_eff || last_start_eff != sample);
  end

  always_comb begin
    push_entry.block_last = block_end;
    push_entry.has_turn   = turn;
    push_entry.turn_len   = old_len;
    push_entry.turn_val   = start_r;
    push_entry.has_close  = close;
    push_entry.close_len  = upd_len;
    push_entry.close_val  = start_upd;
    push_entry.has_end    = endpoint;
    push_entry.end_val    = sample;
    push = accept && (turn || close || endpoint);
  end

  always_comb begin
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    dir_nxt        = dir_r;
    start_nxt      = start_r;
    cnt_nxt        = cnt_r;
    last_start_nxt = last_start_r;
    any_run_nxt    = any_run_r;
    if (accept) begin
      if (block_end) begin
        // Clear everything for the next block.
        prev_nxt       = '0;
        have_prev_nxt  = 1'b0;
        dir_nxt        = DIR_NONE;
        start_nxt      = '0;
        cnt_nxt        = '0;
        last_start_nxt = '0;
        any_run_nxt    = 1'b0;
      end else begin
        prev_nxt       = sample;
        have_prev_nxt  = 1'b1;
        dir_nxt        = dir_upd;
        start_nxt      = start_upd;
        cnt_nxt        = cnt_upd;
        last_start_nxt = last_start_eff;
        any_run_nxt    = any_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      dir_r        <= DIR_NONE;
      start_r      <= '0;
      cnt_r        <= '0;
      last_start_r <= '0;
      any_run_r    <= 1'b0;
    end else begin
      prev_r       <= prev_nxt;
      have_prev_r  <= have_prev_nxt;
      dir_r        <= dir_nxt;
      start_r      <= start_nxt;
      cnt_r        <= cnt_nxt;
      last_start_r <= last_start_nxt;
      any_run_r    <= any_run_nxt;
    end
  end

endmodule

// ===== hw/rtl/mrs_queue.sv =====
// Short queue of record bundles between the front and back ends.
`timescale 1ns / 1ps
module mrs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mrs_pkg::mrs_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output mrs_pkg::mrs_entry_t head_entry
);
  import mrs_pkg::*;

  mrs_entry_t          slots_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/mrs_back.sv =====
// Back end: walks each bundle's records into the output register.
`timescale 1ns / 1ps
module mrs_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 head_valid,
  input  mrs_pkg::mrs_entry_t                  head_entry,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mrs_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser,
  output logic                                 out_tlast
);
  import mrs_pkg::*;

  logic [1:0]          sent_r, sent_nxt;
  logic                valid_r, valid_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SAMPLE_W-1:0] val_r, val_nxt;
  logic                kind_r, kind_nxt;
  logic                last_r, last_nxt;

  logic                pend_turn, pend_close;
  logic                load;
  logic                final_rec;

  assign pend_turn  = head_entry.has_turn && !sent_r[0];
  assign pend_close = head_entry.has_close && !sent_r[1];
  assign load       = head_valid && (!valid_r || out_tready);

  always_comb begin
    len_nxt   = len_r;
    val_nxt   = val_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    sent_nxt  = sent_r;
    final_rec = 1'b1;
    valid_nxt = valid_r && !out_tready;
    if (load) begin
      valid_nxt = 1'b1;
      if (pend_turn) begin
        final_rec = !head_entry.has_close && !head_entry.has_end;
        len_nxt   = head_entry.turn_len;
        val_nxt   = head_entry.turn_val;
        kind_nxt  = KIND_RUN;
        sent_nxt  = sent_r | 2'b01;
      end else if (pend_close) begin
        final_rec = !head_entry.has_end;
        len_nxt   = head_entry.close_len;
        val_nxt   = head_entry.close_val;
        kind_nxt  = KIND_RUN;
        sent_nxt  = sent_r | 2'b10;
      end else begin
        len_nxt   = '0;
        val_nxt   = head_entry.end_val;
        kind_nxt  = KIND_ENDPOINT;
      end
      last_nxt = head_entry.block_last && final_rec;
      if (final_rec) begin
        sent_nxt = 2'b00;
      end
    end
    pop = load && final_rec;
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    val_r  <= val_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 2'b00;
    end else begin
      valid_r <= valid_nxt;
      sent_r  <= sent_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - LEN_W - SAMPLE_W){1'b0}}, val_r, len_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/mrs_checker.sv =====
// Port-level checks for the monotonic run segmenter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);
  import mrs_pkg::*;

  logic in_xfer;
  logic out_stall;
  logic endpoint_rec;

  assign in_xfer      = in_tvalid && in_tready;
  assign out_stall    = out_tvalid && !out_tready;
  assign endpoint_rec = out_tvalid && (out_tuser == KIND_ENDPOINT);

  // A stalled record stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid)
  // A stalled record keeps its payload.
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  // Endpoint records carry a zero run length.
  `ASSERT_IMPLY(a_end_len_zero, clk, rst_n, endpoint_rec, out_tdata[LEN_W-1:0] == '0)
  // An endpoint is always the closing record of its block.
  `ASSERT_IMPLY(a_end_is_last, clk, rst_n, endpoint_rec, out_tlast)
  // Nothing leaves the block in the cycle after reset releases without a prior transaction.
  `ASSERT_NEXT(a_no_early_out, clk, rst_n, $rose(rst_n) && !in_xfer, !out_tvalid)

endmodule

bind monotonic_run_segmenter mrs_checker u_mrs_checker (.*);
